[sv/lbbc_pkg.sv]
// Package for the byte-budget LRU cache directory.
// Holds opcodes, reset constants and the cell command enum; no dependencies.
package lbbc_pkg;

    localparam int DEF_ENTRIES   = 64;
    localparam int DEF_KEY_BITS  = 48;
    localparam int DEF_SIZE_BITS = 24;

    localparam logic [31:0] MAX_BYTES_RESET = 32'd67108864;
    localparam logic [31:0] EXPIRE_RESET    = 32'd3600;

    localparam int TOTAL_BITS = 30;
    localparam int COUNT_BITS = 7;

    typedef enum logic [2:0] {
        OP_HAS     = 3'd0,
        OP_GET     = 3'd1,
        OP_PUT     = 3'd2,
        OP_REMOVE  = 3'd3,
        OP_CLEAR   = 3'd4,
        OP_CLEANUP = 3'd5,
        OP_TRIM    = 3'd6,
        OP_NONE    = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        CFG_MAX_BYTES = 2'd0,
        CFG_ENABLED   = 2'd1,
        CFG_EXPIRE    = 2'd2
    } cfg_idx_t;

    // Broadcast command from the sequencer to every cell.
    typedef enum logic [2:0] {
        CC_IDLE   = 3'd0,
        CC_TOUCH  = 3'd1,
        CC_DROP   = 3'd2,
        CC_INSERT = 3'd3,
        CC_CLEAR  = 3'd4,
        CC_UPDATE = 3'd5
    } cell_cmd_t;

endpackage

[sv/lbbc_cell.sv]
// One directory cell: key, size, stamp, valid and recency rank of one slot.
// Depends on lbbc_pkg. Matches, LRU and expiry flags are combinational per cell.
module lbbc_cell
    import lbbc_pkg::*;
#(
    parameter int KEY_BITS  = DEF_KEY_BITS,
    parameter int SIZE_BITS = DEF_SIZE_BITS,
    parameter int RANK_BITS = 6,
    parameter int CNT_BITS  = 7
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_cmd_t            cmd,
    input  logic                 sel,
    input  logic [RANK_BITS-1:0] ref_rank,
    input  logic [KEY_BITS-1:0]  key,
    input  logic [SIZE_BITS-1:0] size,
    input  logic [31:0]          stamp,
    input  logic [CNT_BITS-1:0]  count,
    input  logic [31:0]          now,
    input  logic [31:0]          expire,
    output logic                 valid,
    output logic                 match,
    output logic                 is_lru,
    output logic                 expired,
    output logic [SIZE_BITS-1:0] size_out,
    output logic [31:0]          stamp_out
);

    logic                 valid_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [SIZE_BITS-1:0] size_reg;
    logic [31:0]          stamp_reg;
    logic [RANK_BITS-1:0] rank_reg;
    logic [31:0]          age;

    assign age = now - stamp_reg;

    // Status flags seen by the sequencer.
    assign valid     = valid_reg;
    assign match     = valid_reg && (key_reg == key);
    assign is_lru    = valid_reg && ({1'b0, rank_reg} + 1'b1 == (RANK_BITS+1)'(count));
    assign expired   = valid_reg && (now > stamp_reg) && (age > expire);
    assign size_out  = size_reg;
    assign stamp_out = stamp_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            case (cmd)
                CC_CLEAR:  valid_reg <= 1'b0;
                CC_DROP:   if (sel) valid_reg <= 1'b0;
                CC_INSERT: if (sel) valid_reg <= 1'b1;
                default:   valid_reg <= valid_reg;
            endcase
        end
    end

    // Payload and rank.
    always_ff @(posedge clk)
    begin
        case (cmd)
            CC_TOUCH:
            begin
                if (sel) rank_reg <= '0;
                else if (valid_reg && rank_reg < ref_rank) rank_reg <= rank_reg + 1'b1;
            end
            CC_UPDATE:
            begin
                if (sel)
                begin
                    rank_reg  <= '0;
                    size_reg  <= size;
                    stamp_reg <= stamp;
                end
                else if (valid_reg && rank_reg < ref_rank) rank_reg <= rank_reg + 1'b1;
            end
            CC_DROP:
            begin
                if (!sel && valid_reg && rank_reg > ref_rank) rank_reg <= rank_reg - 1'b1;
            end
            CC_INSERT:
            begin
                if (sel)
                begin
                    rank_reg  <= '0;
                    key_reg   <= key;
                    size_reg  <= size;
                    stamp_reg <= stamp;
                end
                else if (valid_reg) rank_reg <= rank_reg + 1'b1;
            end
            default:
            begin
                rank_reg <= rank_reg;
            end
        endcase
    end

endmodule

[sv/lbbc_pick.sv]
// Priority picker over a flag vector: one-hot lowest set bit.
// No dependencies beyond parameters.
module lbbc_pick #(
    parameter int N = 64
)
(
    input  logic [N-1:0] flags,
    output logic         any,
    output logic [N-1:0] onehot
);

    // Lowest set bit isolated by two's complement.
    assign onehot = flags & (~flags + 1'b1);
    assign any    = |flags;

endmodule

[sv/lru_byte_budget_cache_directory.sv]
// Byte-budget LRU cache directory built as a row of slot cells.
// Depends on lbbc_pkg, lbbc_cell and lbbc_pick.
//
// Usage: requests enter on in_valid/in_stall with opcode, tile_key,
// tile_bytes and time_now; one result per request leaves on
// out_valid/out_stall. Configuration registers (0 max_bytes, 1 enabled,
// 2 expire_ticks) are written on cfg_valid/cfg_ready while idle.
// Timing: an item is taken in the idle state, then the sequencer issues at
// most one broadcast command to the cell row per cycle. Has, clear, opcode
// seven, a refused put and every miss go from lookup to done; a get, remove
// or put that hits adds an apply step; an insert runs insert and trim, after
// a drop step when a full table frees its LRU slot, plus an apply and trim
// step per entry evicted by the budget; cleanup and trim add a scan step and
// an apply and scan step per removed entry, cleanup with a zero expiry none.
// No item is taken before the last is done; its result is registered on
// the return to idle, so the next item can be taken even while it waits.
// Reset clears all valid bits, the totals and the configuration to its
// reset values; no clearing pass is needed. While out_stall is high the
// result is held and a following result waits in the sequencer.
module lru_byte_budget_cache_directory
    import lbbc_pkg::*;
#(
    parameter int ENTRIES   = DEF_ENTRIES,
    parameter int KEY_BITS  = DEF_KEY_BITS,
    parameter int SIZE_BITS = DEF_SIZE_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [2:0]           opcode,
    input  logic [KEY_BITS-1:0]  tile_key,
    input  logic [SIZE_BITS-1:0] tile_bytes,
    input  logic [31:0]          time_now,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 ok,
    output logic [SIZE_BITS-1:0] hit_bytes,
    output logic [31:0]          hit_time,
    output logic [6:0]           evicted_count,
    output logic [6:0]           entry_count,
    output logic [29:0]          used_bytes,
    output logic                 is_full,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int TW = SIZE_BITS + CW;
    localparam int CMPW = (TW > 32) ? TW : 32;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_LOOK   = 8'b0000_0010,
        S_FULL   = 8'b0000_0100,
        S_INSERT = 8'b0000_1000,
        S_TRIM   = 8'b0001_0000,
        S_CLEAN  = 8'b0010_0000,
        S_APPLY  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    op_t                  op_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [SIZE_BITS-1:0] bytes_reg;
    logic [31:0]          now_reg;
    logic [31:0]          max_reg, expire_reg;
    logic                 enabled_reg;
    logic [TW-1:0]        total_reg, total_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [6:0]           ev_reg, ev_next;
    logic                 ok_reg, ok_next;
    logic [SIZE_BITS-1:0] hb_reg, hb_next;
    logic [31:0]          ht_reg, ht_next;
    logic [ENTRIES-1:0]   sel_reg, sel_next;
    logic [IW-1:0]        rank_sel;
    cell_cmd_t            cmd;
    logic [ENTRIES-1:0]   sel;

    logic [ENTRIES-1:0]   v_vec, m_vec, l_vec, x_vec;
    logic [SIZE_BITS-1:0] c_size [ENTRIES];
    logic [31:0]          c_stamp [ENTRIES];
    logic [IW-1:0]        c_rank [ENTRIES];

    logic                 out_valid_reg;
    logic                 ok_o_reg, full_o_reg;
    logic [SIZE_BITS-1:0] hb_o_reg;
    logic [31:0]          ht_o_reg;
    logic [6:0]           ev_o_reg, cnt_o_reg;
    logic [29:0]          used_o_reg;

    // Put-in-place vs eviction is told apart by a flag set at lookup.
    logic update_reg;

    // Pickers for matching key, free slot, LRU slot and expired slot.
    logic m_any, f_any, l_any, x_any;
    logic [ENTRIES-1:0] m_oh, f_oh, l_oh, x_oh;

    lbbc_pick #(.N(ENTRIES)) u_pm (.flags(m_vec), .any(m_any), .onehot(m_oh));
    lbbc_pick #(.N(ENTRIES)) u_pf (.flags(~v_vec), .any(f_any), .onehot(f_oh));
    lbbc_pick #(.N(ENTRIES)) u_pl (.flags(l_vec), .any(l_any), .onehot(l_oh));
    lbbc_pick #(.N(ENTRIES)) u_px (.flags(x_vec), .any(x_any), .onehot(x_oh));

    // Rank of the selected slot, read through one registered select.
    logic [IW-1:0] sel_rank;
    always_comb
    begin
        sel_rank = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (sel_reg[i]) sel_rank = sel_rank | c_rank[i];
        end
    end
    assign rank_sel = sel_rank;

    // Row of cells; rank is tracked per cell via a mirror below.
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        logic [IW-1:0] rk_reg;
        lbbc_cell #(.KEY_BITS(KEY_BITS), .SIZE_BITS(SIZE_BITS), .RANK_BITS(IW),
            .CNT_BITS(CW)) u_cell (
            .clk(clk), .rst_n(rst_n), .cmd(cmd), .sel(sel[g]), .ref_rank(rank_sel),
            .key(key_reg), .size(bytes_reg), .stamp(now_reg), .count(count_reg),
            .now(now_reg), .expire(expire_reg), .valid(v_vec[g]), .match(m_vec[g]),
            .is_lru(l_vec[g]), .expired(x_vec[g]), .size_out(c_size[g]),
            .stamp_out(c_stamp[g]));
        // Rank mirror following the same commands as the cell.
        always_ff @(posedge clk)
        begin
            case (cmd)
                CC_TOUCH, CC_UPDATE:
                    if (sel[g]) rk_reg <= '0;
                    else if (v_vec[g] && rk_reg < rank_sel) rk_reg <= rk_reg + 1'b1;
                CC_DROP:
                    if (!sel[g] && v_vec[g] && rk_reg > rank_sel) rk_reg <= rk_reg - 1'b1;
                CC_INSERT:
                    if (sel[g]) rk_reg <= '0;
                    else if (v_vec[g]) rk_reg <= rk_reg + 1'b1;
                default: rk_reg <= rk_reg;
            endcase
        end
        assign c_rank[g] = rk_reg;
    end

    // Size and stamp of the selected slot.
    logic [SIZE_BITS-1:0] sel_size;
    logic [31:0]          sel_stamp;
    always_comb
    begin
        sel_size  = '0;
        sel_stamp = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (sel_reg[i])
            begin
                sel_size  = sel_size | c_size[i];
                sel_stamp = sel_stamp | c_stamp[i];
            end
        end
    end

    logic over;
    assign over = (CMPW'(total_reg) > CMPW'(max_reg)) && (count_reg != '0);

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !in_valid;
    assign sel       = sel_reg;

    // Sequencer: one broadcast command per cycle.
    always_comb
    begin
        state_next = state_reg;
        total_next = total_reg;
        count_next = count_reg;
        ev_next    = ev_reg;
        ok_next    = ok_reg;
        hb_next    = hb_reg;
        ht_next    = ht_reg;
        sel_next   = sel_reg;
        cmd        = CC_IDLE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid) state_next = S_LOOK;
                ev_next = '0;
                ok_next = 1'b1;
                hb_next = '0;
                ht_next = '0;
            end
            S_LOOK:
            begin
                sel_next   = m_oh;
                state_next = S_DONE;
                case (op_reg)
                    OP_HAS: ok_next = m_any;
                    OP_GET, OP_REMOVE:
                    begin
                        ok_next = m_any;
                        if (m_any) state_next = S_APPLY;
                    end
                    OP_PUT:
                    begin
                        if (!enabled_reg) ok_next = 1'b0;
                        else if (m_any) state_next = S_APPLY;
                        else if (!f_any)
                        begin
                            sel_next   = l_oh;
                            state_next = l_any ? S_FULL : S_DONE;
                            ok_next    = l_any;
                        end
                        else
                        begin
                            sel_next   = f_oh;
                            state_next = S_INSERT;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd        = CC_CLEAR;
                        total_next = '0;
                        count_next = '0;
                    end
                    OP_CLEANUP: if (expire_reg != '0) state_next = S_CLEAN;
                    OP_TRIM:    state_next = S_TRIM;
                    default:    state_next = S_DONE;
                endcase
            end
            S_FULL:
            begin
                // Drop the LRU slot, then take the freed slot.
                cmd        = CC_DROP;
                total_next = total_reg - TW'(sel_size);
                count_next = count_reg - 1'b1;
                ev_next    = ev_reg + 1'b1;
                sel_next   = sel_reg;
                state_next = S_INSERT;
            end
            S_INSERT:
            begin
                cmd        = CC_INSERT;
                total_next = total_reg + TW'(bytes_reg);
                count_next = count_reg + 1'b1;
                state_next = S_TRIM;
            end
            S_TRIM:
            begin
                if (over && l_any)
                begin
                    sel_next   = l_oh;
                    state_next = S_APPLY;
                end
                else state_next = S_DONE;
            end
            S_CLEAN:
            begin
                if (x_any)
                begin
                    sel_next   = x_oh;
                    state_next = S_APPLY;
                end
                else state_next = S_DONE;
            end
            S_APPLY:
            begin
                state_next = S_DONE;
                case (op_reg)
                    OP_GET:
                    begin
                        cmd     = CC_TOUCH;
                        hb_next = sel_size;
                        ht_next = sel_stamp;
                    end
                    OP_PUT:
                    begin
                        if (update_reg)
                        begin
                            cmd        = CC_UPDATE;
                            total_next = total_reg - TW'(sel_size) + TW'(bytes_reg);
                        end
                        else
                        begin
                            cmd        = CC_DROP;
                            total_next = total_reg - TW'(sel_size);
                            count_next = count_reg - 1'b1;
                            ev_next    = ev_reg + 1'b1;
                            state_next = S_TRIM;
                        end
                    end
                    OP_REMOVE:
                    begin
                        cmd        = CC_DROP;
                        total_next = total_reg - TW'(sel_size);
                        count_next = count_reg - 1'b1;
                    end
                    OP_CLEANUP, OP_TRIM:
                    begin
                        cmd        = CC_DROP;
                        total_next = total_reg - TW'(sel_size);
                        count_next = count_reg - 1'b1;
                        ev_next    = ev_reg + 1'b1;
                        state_next = (op_reg == OP_CLEANUP) ? S_CLEAN : S_TRIM;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            count_reg     <= '0;
            sel_reg       <= '0;
            max_reg       <= MAX_BYTES_RESET;
            enabled_reg   <= 1'b1;
            expire_reg    <= EXPIRE_RESET;
            out_valid_reg <= 1'b0;
            update_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            count_reg <= count_next;
            sel_reg   <= sel_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MAX_BYTES: max_reg     <= cfg_data;
                    CFG_ENABLED:   enabled_reg <= cfg_data[0];
                    CFG_EXPIRE:    expire_reg  <= cfg_data;
                    default:       max_reg     <= max_reg;
                endcase
            end
            if (state_reg == S_LOOK) update_reg <= (op_reg == OP_PUT) && m_any;
            if (state_reg == S_DONE && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers and output register.
    always_ff @(posedge clk)
    begin
        ev_reg  <= ev_next;
        ok_reg  <= ok_next;
        hb_reg  <= hb_next;
        ht_reg  <= ht_next;
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg    <= op_t'(opcode);
            key_reg   <= tile_key;
            bytes_reg <= tile_bytes;
            now_reg   <= time_now;
        end
        if (state_reg == S_DONE && (!out_valid_reg || !out_stall))
        begin
            ok_o_reg   <= ok_reg;
            hb_o_reg   <= hb_reg;
            ht_o_reg   <= ht_reg;
            ev_o_reg   <= ev_reg;
            cnt_o_reg  <= 7'(count_reg);
            used_o_reg <= 30'(total_reg);
            full_o_reg <= CMPW'(total_reg) >= CMPW'(max_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign ok            = ok_o_reg;
    assign hit_bytes     = hb_o_reg;
    assign hit_time      = ht_o_reg;
    assign evicted_count = ev_o_reg;
    assign entry_count   = cnt_o_reg;
    assign used_bytes    = used_o_reg;
    assign is_full       = full_o_reg;

    // A stalled result must not be overwritten.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(ev_o_reg))
        else $error("result changed under stall");

    // Only one slot is addressed by a command at a time.
    a_sel: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(sel_reg)) else $error("multiple slots selected");

    // Valid count tracks the valid bits of the cell row.
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> $countones(v_vec) == int'(count_reg))
        else $error("valid count mismatch");

endmodule
